// ----- rtl/tds_pkg.sv -----
// ----------------------------------------------------------------------------
// tds_pkg: shared types and constants for the timer divider solver
// Widths of the serial divider, scale factors and divider control structs.
// ----------------------------------------------------------------------------
package tds_pkg;

	localparam int unsigned RELOAD_MAX_DEF    = 65535;
	localparam int unsigned PRESCALER_MAX_DEF = 65535;

	// config port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// field widths
	localparam int TGT_W  = 31;
	localparam int TCLK_W = 32;

	// serial divider: dividend up to 62 bits, divisor up to 49 bits
	localparam int DVD_W  = 64;
	localparam int DVR_W  = 49;
	localparam int STEP_W = 7;

	localparam logic [STEP_W-1:0] STEPS_CLK   = 7'd32;
	localparam logic [STEP_W-1:0] STEPS_MICRO = 7'd52;
	localparam logic [STEP_W-1:0] STEPS_PPB   = 7'd62;

	localparam logic [31:0] MICRO_SCALE = 32'd1000000;
	localparam logic [31:0] PPB_SCALE   = 32'd1000000000;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} tds_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tds_div_sts_t;

endpackage

// ----- rtl/timer_divider_solver.sv -----
// ----------------------------------------------------------------------------
// timer_divider_solver: prescaler and reload solver for a toggling timer
// Finds prescaler/reload for a wanted square-wave frequency, plus the
// achieved frequency and its error in parts per billion.
// ----------------------------------------------------------------------------
// Usage
//   Config: APB-style write port. 0x0 bus_clock_hz (31 bit), 0x4
//   bus_divider_code (3 bit). Codes 4..7 double the timer clock. Write only
//   while busy is low. Reads return the stored values.
//   Command: a word is taken on the clock edge where start is high and busy
//   is low. busy then stays high until the result goes out.
//   Result: done pulses for one cycle with ok, prescaler, reload,
//   achieved_hz_whole, achieved_hz_micro and error_ppb valid in that cycle.
//   The receiver cannot stall; fields hold until the next result.
// Sequence
//   On success done follows five runs of the shared bit-serial divider
//   (32, 32, 32, 52 and 62 steps) with multiply states before and between
//   them. A zero target or clock ends the solve in the first multiply state,
//   a prescaler out of range after the first divider run, a target too
//   high after the second. A new word can be taken on the edge that ends
//   the done cycle.
// Reset
//   arst_n clears the sequencer and loads 42 MHz / divider code 4.
// ----------------------------------------------------------------------------
module timer_divider_solver #(
	parameter int unsigned RELOAD_MAX    = tds_pkg::RELOAD_MAX_DEF,
	parameter int unsigned PRESCALER_MAX = tds_pkg::PRESCALER_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tds_pkg::ADDR_W-1:0]  paddr,
	input  logic [tds_pkg::DATA_W-1:0]  pwdata,
	output logic [tds_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// command
	input  logic                        start,
	input  logic [tds_pkg::TGT_W-1:0]   target_freq,
	output logic                        busy,
	// result
	output logic                        done,
	output logic                        ok,
	output logic [15:0]                 prescaler,
	output logic [15:0]                 reload,
	output logic [31:0]                 achieved_hz_whole,
	output logic [19:0]                 achieved_hz_micro,
	output logic [29:0]                 error_ppb
);
	import tds_pkg::*;

	// register select is paddr[2]
	localparam logic REG_BUS_CLOCK = 1'b0;
	localparam logic REG_BUS_DIV   = 1'b1;

	// count span searched per prescaler step: (RELOAD_MAX + 1) + 1
	localparam logic [31:0] TOP_SPAN = 32'(RELOAD_MAX + 2);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_TOP,
		S_DIV_P,
		S_MUL_Q,
		S_DIV_Q,
		S_MUL_D,
		S_MUL_TD,
		S_DIV_W,
		S_MUL_U,
		S_DIV_U,
		S_MUL_E,
		S_DIV_E
	} state_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] prescaler;
		logic [15:0] reload;
		logic [31:0] whole;
		logic [19:0] micro;
		logic [29:0] ppb;
	} res_t;

	// config registers
	logic [30:0] bus_clock_q;
	logic [2:0]  bus_div_q;
	logic        cfg_wr;

	// sequencer
	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   div_go_q;
	res_t   res_q;

	// working values
	logic [TGT_W-1:0]  target_q;
	logic [TCLK_W-1:0] tclk_q;
	logic [15:0]       p_q;
	logic [16:0]       q_q;
	logic [31:0]       d_q;
	logic [31:0]       td_q;
	logic [31:0]       diff_q;
	logic [31:0]       whole_q;
	logic [31:0]       frac_q;
	logic [19:0]       micro_q;
	logic [63:0]       mul_q;

	logic [TCLK_W-1:0] tclk;
	logic [31:0]       rate;
	logic [16:0]       p1;
	logic              accept;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic        mul_en;

	tds_div_ctl_t     div_ctl;
	tds_div_sts_t     div_sts;
	logic [DVD_W-1:0] div_dvd;
	logic [DVR_W-1:0] div_dvr;
	logic [DVD_W-1:0] div_quo;
	logic [DVR_W-1:0] div_rem;

	// ------------------------------------------------------------------
	// config port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_clock_q <= 31'd42000000;
			bus_div_q   <= 3'd4;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_BUS_CLOCK: bus_clock_q <= pwdata[30:0];
				REG_BUS_DIV:   bus_div_q   <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BUS_CLOCK: prdata = {1'b0, bus_clock_q};
			REG_BUS_DIV:   prdata = {29'b0, bus_div_q};
			default:       prdata = '0;
		endcase
	end

	// codes 4..7 have bit 2 set: timer clock runs at twice the bus clock
	assign tclk   = bus_div_q[2] ? {bus_clock_q, 1'b0} : {1'b0, bus_clock_q};
	assign accept = start & ~busy_q;
	assign rate   = {target_q, 1'b0};
	assign p1     = {1'b0, p_q} + 17'd1;

	// ------------------------------------------------------------------
	// shared multiplier, product registered
	// ------------------------------------------------------------------
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b0;
		case (state_q)
			S_MUL_TOP: begin
				mul_a  = rate;
				mul_b  = TOP_SPAN;
				mul_en = 1'b1;
			end
			S_MUL_Q: begin
				mul_a  = rate;
				mul_b  = {15'b0, p1};
				mul_en = 1'b1;
			end
			S_MUL_D: begin
				mul_a  = {15'b0, q_q};
				mul_b  = {15'b0, p1};
				mul_en = 1'b1;
			end
			S_MUL_TD: begin
				// d = 2*(p+1)*q never exceeds the timer clock
				mul_a  = {mul_q[30:0], 1'b0};
				mul_b  = {1'b0, target_q};
				mul_en = 1'b1;
			end
			S_MUL_U: begin
				mul_a  = frac_q;
				mul_b  = MICRO_SCALE;
				mul_en = 1'b1;
			end
			S_MUL_E: begin
				mul_a  = diff_q;
				mul_b  = PPB_SCALE;
				mul_en = 1'b1;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// divider operands
	// ------------------------------------------------------------------
	always_comb begin
		div_ctl.start = div_go_q;
		div_ctl.steps = STEPS_CLK;
		div_dvd       = {tclk_q, 32'b0};
		div_dvr       = mul_q[DVR_W-1:0];
		case (state_q)
			S_DIV_W: begin
				div_dvr = {17'b0, d_q};
			end
			S_DIV_U: begin
				div_ctl.steps = STEPS_MICRO;
				div_dvd       = {mul_q[51:0], 12'b0};
				div_dvr       = {17'b0, d_q};
			end
			S_DIV_E: begin
				div_ctl.steps = STEPS_PPB;
				div_dvd       = {mul_q[61:0], 2'b0};
				div_dvr       = {17'b0, td_q};
			end
			default: ;
		endcase
	end

	tds_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_dvd),
		.divisor   (div_dvr),
		.sts       (div_sts),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// ------------------------------------------------------------------
	// sequencer: state and registered result
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			res_q    <= '0;
		end else begin
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						busy_q  <= 1'b1;
						state_q <= S_MUL_TOP;
					end
				end
				S_MUL_TOP: begin
					if (target_q == '0 || tclk_q == '0) begin
						res_q   <= '0;
						done_q  <= 1'b1;
						busy_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= S_DIV_P;
					end
				end
				S_DIV_P: begin
					if (div_sts.done) begin
						if (div_quo > 64'(PRESCALER_MAX)) begin
							res_q   <= '0;
							done_q  <= 1'b1;
							busy_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MUL_Q;
						end
					end
				end
				S_MUL_Q: begin
					div_go_q <= 1'b1;
					state_q  <= S_DIV_Q;
				end
				S_DIV_Q: begin
					if (div_sts.done) begin
						// target too high for any count
						if (div_quo == '0) begin
							res_q   <= '0;
							done_q  <= 1'b1;
							busy_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MUL_D;
						end
					end
				end
				S_MUL_D: begin
					state_q <= S_MUL_TD;
				end
				S_MUL_TD: begin
					div_go_q <= 1'b1;
					state_q  <= S_DIV_W;
				end
				S_DIV_W: begin
					if (div_sts.done) state_q <= S_MUL_U;
				end
				S_MUL_U: begin
					div_go_q <= 1'b1;
					state_q  <= S_DIV_U;
				end
				S_DIV_U: begin
					if (div_sts.done) state_q <= S_MUL_E;
				end
				S_MUL_E: begin
					div_go_q <= 1'b1;
					state_q  <= S_DIV_E;
				end
				S_DIV_E: begin
					if (div_sts.done) begin
						res_q.ok        <= 1'b1;
						res_q.prescaler <= p_q;
						res_q.reload    <= 16'(q_q - 17'd1);
						res_q.whole     <= whole_q;
						res_q.micro     <= micro_q;
						res_q.ppb       <= div_quo[29:0];
						done_q          <= 1'b1;
						busy_q          <= 1'b0;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// working values
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mul_en) mul_q <= {32'b0, mul_a} * {32'b0, mul_b};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					target_q <= target_freq;
					tclk_q   <= tclk;
				end
			end
			S_DIV_P: begin
				if (div_sts.done) p_q <= div_quo[15:0];
			end
			S_DIV_Q: begin
				// q is at most RELOAD_MAX + 1
				if (div_sts.done) q_q <= div_quo[16:0];
			end
			S_MUL_TD: begin
				d_q <= {mul_q[30:0], 1'b0};
			end
			S_DIV_W: begin
				// target*d fits the timer clock, so the low word is exact
				if (div_go_q) begin
					td_q   <= mul_q[31:0];
					diff_q <= tclk_q - mul_q[31:0];
				end
				if (div_sts.done) begin
					whole_q <= div_quo[31:0];
					frac_q  <= div_rem[31:0];
				end
			end
			S_DIV_U: begin
				if (div_sts.done) micro_q <= div_quo[19:0];
			end
			default: ;
		endcase
	end

	assign busy              = busy_q;
	assign done              = done_q;
	assign ok                = res_q.ok;
	assign prescaler         = res_q.prescaler;
	assign reload            = res_q.reload;
	assign achieved_hz_whole = res_q.whole;
	assign achieved_hz_micro = res_q.micro;
	assign error_ppb         = res_q.ppb;

endmodule

// ----- rtl/tds_div.sv -----
// ----------------------------------------------------------------------------
// tds_div: bit-serial restoring divider
// One quotient bit per cycle; dividend is loaded left-aligned, steps sets
// how many of its top bits take part.
// ----------------------------------------------------------------------------
module tds_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tds_pkg::tds_div_ctl_t      ctl,
	input  logic [tds_pkg::DVD_W-1:0]  dividend,
	input  logic [tds_pkg::DVR_W-1:0]  divisor,
	output tds_pkg::tds_div_sts_t      sts,
	output logic [tds_pkg::DVD_W-1:0]  quotient,
	output logic [tds_pkg::DVR_W-1:0]  remainder
);
	import tds_pkg::*;

	logic [DVR_W-1:0]  rem_q;
	logic [DVR_W-1:0]  dvr_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DVR_W:0] trial;
	logic [DVR_W:0] sub;
	logic           ge;

	// partial remainder stays below the divisor, so the sign of sub decides
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign sub   = trial - {1'b0, dvr_q};
	assign ge    = ~sub[DVR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dvr_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? sub[DVR_W-1:0] : trial[DVR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/tds_chk.sv -----
// ----------------------------------------------------------------------------
// tds_chk: port-level checks for the timer divider solver
// Watches the command and result ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tds_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        ok,
	input logic [15:0] prescaler,
	input logic [15:0] reload,
	input logic [31:0] achieved_hz_whole,
	input logic [19:0] achieved_hz_micro,
	input logic [29:0] error_ppb
);

	// an accepted word raises busy in the following cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted word");

	// result strobe is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// failed solve reports all fields zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> prescaler == 16'd0 && reload == 16'd0 &&
			achieved_hz_whole == 32'd0 && achieved_hz_micro == 20'd0 &&
			error_ppb == 30'd0)
		else $error("nonzero field on failed result");

	// micro part is a six-digit fraction
	a_micro_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && ok |-> achieved_hz_micro < 20'd1000000)
		else $error("micro part out of range");

	// quotient rounds down, so the error stays below one part in one
	a_ppb_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && ok |-> error_ppb < 30'd1000000000)
		else $error("error_ppb out of range");

endmodule

bind timer_divider_solver tds_chk u_tds_chk (.*);
